@@ rtl/ccc_pkg.sv @@
// Shared types and constants for the circle-circle collision pipeline.
`default_nettype none
package ccc_pkg;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 15;
  localparam int unsigned DIV_LANES   = 2;

  localparam logic [15:0] THR_RESET = 16'd4295;
  localparam logic [15:0] ONE_Q14   = 16'd16384;

  // Side information that travels with an item through the root and divide stages.
  typedef struct packed {
    logic        hit;
    logic        coin;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] r;
  } ctx_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [31:0] penetration;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/ccc_in_if.sv @@
// Input channel: two circle centres and radii with valid/ready.
`default_nettype none
interface ccc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_pos_x;
  logic [31:0] a_pos_y;
  logic [31:0] b_pos_x;
  logic [31:0] b_pos_y;
  logic [30:0] a_radius;
  logic [30:0] b_radius;

  modport source (output valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_radius, b_radius,
                  input ready);
  modport sink   (input valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_radius, b_radius,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/ccc_out_if.sv @@
// Result channel: hit flag, unit normal and penetration with valid/ready.
`default_nettype none
interface ccc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] normal_x;
  logic [15:0] normal_y;
  logic [31:0] penetration;

  modport source (output valid, hit, normal_x, normal_y, penetration, input ready);
  modport sink   (input valid, hit, normal_x, normal_y, penetration, output ready);
endinterface
`default_nettype wire

@@ rtl/ccc_sqrt.sv @@
// Pipelined 64-bit integer square root, one root bit per stage.
`default_nettype none
module ccc_sqrt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [63:0]   in_val,
  input  wire ccc_pkg::ctx_t in_ctx,
  output logic               out_valid,
  output logic [31:0]        out_root,
  output ccc_pkg::ctx_t      out_ctx
);

  localparam int unsigned N = ccc_pkg::SQRT_STAGES;

  logic [N-1:0]  v_r;
  logic [N-1:0]  v_nxt;
  logic [33:0]   rem_r   [N];
  logic [31:0]   root_r  [N];
  logic [63:0]   val_r   [N];
  ccc_pkg::ctx_t ctx_r   [N];

  logic [33:0]   rem_p    [N];
  logic [31:0]   root_p   [N];
  logic [63:0]   val_p    [N];
  ccc_pkg::ctx_t ctx_p    [N];
  logic [34:0]   rem_sh   [N];
  logic [34:0]   trial    [N];
  logic [33:0]   rem_nxt  [N];
  logic [31:0]   root_nxt [N];
  logic [63:0]   val_nxt  [N];

  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    val_p[0]  = in_val;
    ctx_p[0]  = in_ctx;
    for (int s = 1; s < N; s++) begin
      rem_p[s]  = rem_r[s-1];
      root_p[s] = root_r[s-1];
      val_p[s]  = val_r[s-1];
      ctx_p[s]  = ctx_r[s-1];
    end
  end

  always_comb begin
    v_nxt = {v_r[N-2:0], in_valid};
    for (int s = 0; s < N; s++) begin
      // bring down the next two radicand bits, try root*4+1
      rem_sh[s] = {rem_p[s][32:0], val_p[s][63:62]};
      trial[s]  = {1'b0, root_p[s], 2'b01};
      if (rem_sh[s] >= trial[s]) begin
        rem_nxt[s]  = 34'(rem_sh[s] - trial[s]);
        root_nxt[s] = {root_p[s][30:0], 1'b1};
      end else begin
        rem_nxt[s]  = rem_sh[s][33:0];
        root_nxt[s] = {root_p[s][30:0], 1'b0};
      end
      val_nxt[s] = {val_p[s][61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        val_r[s]  <= val_nxt[s];
        ctx_r[s]  <= ctx_p[s];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_ctx   = ctx_r[N-1];

endmodule
`default_nettype wire

@@ rtl/ccc_div.sv @@
// Pipelined rounded divide of both normal components by the distance.
`default_nettype none
module ccc_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [31:0]   in_d,
  input  wire ccc_pkg::ctx_t in_ctx,
  output logic               out_valid,
  output logic [14:0]        out_qx,
  output logic [14:0]        out_qy,
  output logic [31:0]        out_d,
  output ccc_pkg::ctx_t      out_ctx
);

  localparam int unsigned N = ccc_pkg::DIV_STAGES;
  localparam int unsigned L = ccc_pkg::DIV_LANES;

  // entry stage: numerator = mag * 2^14 + d/2
  logic          v0_r;
  logic [45:0]   num0_r [L];
  logic [31:0]   d0_r;
  ccc_pkg::ctx_t ctx0_r;

  logic [N-1:0]  v_r;
  logic [31:0]   rem_r  [N][L];
  logic [14:0]   low_r  [N][L];
  logic [14:0]   q_r    [N][L];
  logic [31:0]   d_r    [N];
  ccc_pkg::ctx_t ctx_r  [N];

  logic [31:0]   mag      [L];
  logic [45:0]   num_nxt  [L];
  logic [31:0]   rem_p    [N][L];
  logic [14:0]   low_p    [N][L];
  logic [14:0]   q_p      [N][L];
  logic [31:0]   d_p      [N];
  ccc_pkg::ctx_t ctx_p    [N];
  logic [32:0]   rem_sh   [N][L];
  logic [31:0]   rem_nxt  [N][L];
  logic [14:0]   low_nxt  [N][L];
  logic [14:0]   q_nxt    [N][L];

  always_comb begin
    mag[0] = in_ctx.ux;
    mag[1] = in_ctx.uy;
    for (int l = 0; l < L; l++) begin
      num_nxt[l] = {mag[l], 14'd0} + {15'd0, in_d[31:1]};
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      rem_p[0][l] = {1'b0, num0_r[l][45:15]};
      low_p[0][l] = num0_r[l][14:0];
      q_p[0][l]   = '0;
    end
    d_p[0]   = d0_r;
    ctx_p[0] = ctx0_r;
    for (int s = 1; s < N; s++) begin
      for (int l = 0; l < L; l++) begin
        rem_p[s][l] = rem_r[s-1][l];
        low_p[s][l] = low_r[s-1][l];
        q_p[s][l]   = q_r[s-1][l];
      end
      d_p[s]   = d_r[s-1];
      ctx_p[s] = ctx_r[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < N; s++) begin
      for (int l = 0; l < L; l++) begin
        rem_sh[s][l] = {rem_p[s][l], low_p[s][l][14]};
        if (rem_sh[s][l] >= {1'b0, d_p[s]}) begin
          rem_nxt[s][l] = 32'(rem_sh[s][l] - {1'b0, d_p[s]});
          q_nxt[s][l]   = {q_p[s][l][13:0], 1'b1};
        end else begin
          rem_nxt[s][l] = rem_sh[s][l][31:0];
          q_nxt[s][l]   = {q_p[s][l][13:0], 1'b0};
        end
        low_nxt[s][l] = {low_p[s][l][13:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
    end else if (en) begin
      v0_r <= in_valid;
      v_r  <= {v_r[N-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        num0_r[l] <= num_nxt[l];
      end
      d0_r   <= in_d;
      ctx0_r <= in_ctx;
      for (int s = 0; s < N; s++) begin
        for (int l = 0; l < L; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          low_r[s][l] <= low_nxt[s][l];
          q_r[s][l]   <= q_nxt[s][l];
        end
        d_r[s]   <= d_p[s];
        ctx_r[s] <= ctx_p[s];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_qx    = q_r[N-1][0];
  assign out_qy    = q_r[N-1][1];
  assign out_d     = d_r[N-1];
  assign out_ctx   = ctx_r[N-1];

endmodule
`default_nettype wire

@@ rtl/ccc_skid.sv @@
// Two-entry output buffer that decouples the pipeline from the result channel.
`default_nettype none
module ccc_skid (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ccc_pkg::res_t push_data,
  input  wire logic          pop_ready,
  output logic               full,
  output logic               out_valid,
  output ccc_pkg::res_t      out_data
);

  ccc_pkg::res_t buf_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid & pop_ready;
  assign out_data  = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/circle_circle_collision.sv @@
// Circle-circle collision test. Throughput one transaction per cycle while the output
// buffer has room; the square root advances one bit per stage (32) and the divider one
// quotient bit per stage (15), plus five front and one entry stage.
// The whole pipeline holds while the two-entry output buffer is full.
// Synchronous active-low reset clears valid bits and sets the threshold to 4295.
`default_nettype none
module circle_circle_collision (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  ccc_in_if.sink           in_ch,
  ccc_out_if.source        out_ch
);

  logic en;
  logic skid_full;
  logic [15:0] thr_r;

  // stage 1: offsets and radius sum
  logic        v1_r;
  logic [32:0] dx_r, dy_r;
  logic [31:0] r1_r;
  // stage 2: magnitudes
  logic        v2_r;
  logic [31:0] ux2_r, uy2_r, r2s_r;
  logic        nx2_r, ny2_r;
  logic [32:0] ux_full, uy_full;
  // stage 3: squares
  logic        v3_r;
  logic [63:0] sx_r, sy_r, rr3_r;
  logic [31:0] ux3_r, uy3_r, r3_r;
  logic        nx3_r, ny3_r;
  // stage 4: squared distance
  logic        v4_r;
  logic [64:0] dist2_r;
  logic [63:0] rr4_r;
  logic [31:0] ux4_r, uy4_r, r4_r;
  logic        nx4_r, ny4_r;
  // stage 5: classify
  logic          v5_r;
  logic [63:0]   val5_r;
  ccc_pkg::ctx_t ctx5_r, ctx5_nxt;

  logic          sq_valid;
  logic [31:0]   sq_root;
  ccc_pkg::ctx_t sq_ctx;

  logic          dv_valid;
  logic [14:0]   dv_qx, dv_qy;
  logic [31:0]   dv_d;
  ccc_pkg::ctx_t dv_ctx;

  ccc_pkg::res_t res;

  assign en          = ~skid_full;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ccc_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    ux_full = dx_r[32] ? 33'(~dx_r + 33'd1) : dx_r;
    uy_full = dy_r[32] ? 33'(~dy_r + 33'd1) : dy_r;
  end

  always_comb begin
    ctx5_nxt.hit   = (dist2_r < {1'b0, rr4_r});
    ctx5_nxt.coin  = (dist2_r < {49'd0, thr_r}) || (dist2_r == 65'd0);
    ctx5_nxt.neg_x = nx4_r;
    ctx5_nxt.neg_y = ny4_r;
    ctx5_nxt.ux    = ux4_r;
    ctx5_nxt.uy    = uy4_r;
    ctx5_nxt.r     = r4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= {in_ch.b_pos_x[31], in_ch.b_pos_x} - {in_ch.a_pos_x[31], in_ch.a_pos_x};
      dy_r  <= {in_ch.b_pos_y[31], in_ch.b_pos_y} - {in_ch.a_pos_y[31], in_ch.a_pos_y};
      r1_r  <= {1'b0, in_ch.a_radius} + {1'b0, in_ch.b_radius};

      ux2_r <= ux_full[31:0];
      uy2_r <= uy_full[31:0];
      nx2_r <= dx_r[32];
      ny2_r <= dy_r[32];
      r2s_r <= r1_r;

      sx_r  <= {32'd0, ux2_r} * {32'd0, ux2_r};
      sy_r  <= {32'd0, uy2_r} * {32'd0, uy2_r};
      rr3_r <= {32'd0, r2s_r} * {32'd0, r2s_r};
      ux3_r <= ux2_r;
      uy3_r <= uy2_r;
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      r3_r  <= r2s_r;

      dist2_r <= {1'b0, sx_r} + {1'b0, sy_r};
      rr4_r   <= rr3_r;
      ux4_r   <= ux3_r;
      uy4_r   <= uy3_r;
      nx4_r   <= nx3_r;
      ny4_r   <= ny3_r;
      r4_r    <= r3_r;

      val5_r <= dist2_r[63:0];
      ctx5_r <= ctx5_nxt;
    end
  end

  ccc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_val    (val5_r),
    .in_ctx    (ctx5_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_ctx   (sq_ctx)
  );

  ccc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_d      (sq_root),
    .in_ctx    (sq_ctx),
    .out_valid (dv_valid),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_d     (dv_d),
    .out_ctx   (dv_ctx)
  );

  always_comb begin
    res = '0;
    if (dv_ctx.hit) begin
      res.hit = 1'b1;
      if (dv_ctx.coin) begin
        res.normal_x    = ccc_pkg::ONE_Q14;
        res.normal_y    = '0;
        res.penetration = dv_ctx.r;
      end else begin
        // restore the sign of each offset on the rounded magnitude
        res.normal_x    = dv_ctx.neg_x ? 16'(~{1'b0, dv_qx} + 16'd1) : {1'b0, dv_qx};
        res.normal_y    = dv_ctx.neg_y ? 16'(~{1'b0, dv_qy} + 16'd1) : {1'b0, dv_qy};
        res.penetration = dv_ctx.r - dv_d;
      end
    end
  end

  ccc_pkg::res_t skid_out;

  ccc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en & dv_valid),
    .push_data (res),
    .pop_ready (out_ch.ready),
    .full      (skid_full),
    .out_valid (out_ch.valid),
    .out_data  (skid_out)
  );

  assign out_ch.hit         = skid_out.hit;
  assign out_ch.normal_x    = skid_out.normal_x;
  assign out_ch.normal_y    = skid_out.normal_y;
  assign out_ch.penetration = skid_out.penetration;

endmodule
`default_nettype wire

@@ bench/circle_circle_collision_test.sv @@
// Testbench for circle_circle_collision: random and directed circle pairs checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class collision_scoreboard;
  ccc_pkg::res_t expected_q[$];
  int            error_count;

  function void note_pair(input ccc_pkg::res_t r);
    expected_q.push_back(r);
  endfunction

  function void check_result(input ccc_pkg::res_t got);
    ccc_pkg::res_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result transaction");
      error_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, actual %0d", want.hit, got.hit);
      error_count++;
    end
    if (got.normal_x !== want.normal_x) begin
      $error("normal_x: expected %h, actual %h", want.normal_x, got.normal_x);
      error_count++;
    end
    if (got.normal_y !== want.normal_y) begin
      $error("normal_y: expected %h, actual %h", want.normal_y, got.normal_y);
      error_count++;
    end
    if (got.penetration !== want.penetration) begin
      $error("penetration: expected %h, actual %h", want.penetration, got.penetration);
      error_count++;
    end
  endfunction
endclass

module circle_circle_collision_test;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = '0;
  logic [15:0] threshold;
  int          in_idle_pct;
  int          out_idle_pct;
  bit          stim_done;

  ccc_in_if  in_ch ();
  ccc_out_if out_ch ();

  collision_scoreboard board = new();

  circle_circle_collision i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] floor_root(input logic [65:0] v);
    logic [65:0] res;
    logic [65:0] bitv;
    res = 0;
    bitv = 66'd1 << 64;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[63:0];
  endfunction

  function automatic logic [15:0] unit_comp(input logic signed [33:0] delta, input logic [63:0] d);
    logic [33:0] mag;
    logic [79:0] q;
    mag = delta < 0 ? -delta : delta;
    q = ({46'd0, mag} * 80'd16384 + {16'd0, d >> 1}) / {16'd0, d};
    if (delta < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic ccc_pkg::res_t predict_contact(input logic [31:0] ax, ay, bx, by,
                                                    input logic [30:0] ar, br);
    logic signed [33:0] dx, dy;
    logic [33:0]        ux, uy;
    logic [65:0]        dist2;
    logic [32:0]        r;
    logic [65:0]        r2;
    logic [63:0]        d;
    ccc_pkg::res_t      o;
    dx = $signed({{2{bx[31]}}, bx}) - $signed({{2{ax[31]}}, ax});
    dy = $signed({{2{by[31]}}, by}) - $signed({{2{ay[31]}}, ay});
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    dist2 = {32'd0, ux} * {32'd0, ux} + {32'd0, uy} * {32'd0, uy};
    r = {2'b0, ar} + {2'b0, br};
    r2 = {33'd0, r} * {33'd0, r};
    o = '0;
    // a squared distance past 64 bits counts as no hit
    if (dist2[65:64] != 0 || dist2 >= r2) return o;
    o.hit = 1;
    if (dist2 < {50'd0, threshold} || dist2 == 0) begin
      o.normal_x = ccc_pkg::ONE_Q14;
      o.penetration = r[31:0];
      return o;
    end
    d = floor_root(dist2);
    o.normal_x = unit_comp(dx, d);
    o.normal_y = unit_comp(dy, d);
    o.penetration = r[31:0] - d[31:0];
    return o;
  endfunction

  task automatic send_pair(input logic [31:0] ax, ay, bx, by, input logic [30:0] ar, br);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.a_pos_x <= ax; in_ch.a_pos_y <= ay;
    in_ch.b_pos_x <= bx; in_ch.b_pos_y <= by;
    in_ch.a_radius <= ar; in_ch.b_radius <= br;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_pair(predict_contact(ax, ay, bx, by, ar, br));
    @(negedge clk);
  endtask

  task automatic drain_and_pause();
    in_ch.valid <= 0;
    while (board.expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_wr_en <= 1; cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    threshold = v;
  endtask

  // mostly nearby circles so hits, coincidence and roots all get exercised
  task automatic send_random_pair();
    logic [31:0] ax, ay, bx, by;
    logic [30:0] ar, br;
    int          shift;
    shift = $urandom_range(31);
    ax = $urandom; ay = $urandom;
    case ($urandom_range(3))
      0: begin
        bx = $urandom; by = $urandom; ar = 31'($urandom); br = 31'($urandom);
      end
      1: begin
        bx = ax + ($signed($urandom) >>> shift);
        by = ay + ($signed($urandom) >>> shift);
        ar = 31'($urandom >> shift); br = 31'($urandom >> ($urandom_range(31)));
      end
      2: begin
        bx = ax + $urandom_range(0, 255) - 128;
        by = ay + $urandom_range(0, 255) - 128;
        ar = 31'($urandom_range(0, 300)); br = 31'($urandom_range(0, 300));
      end
      default: begin
        bx = ax + ($signed($urandom) >>> shift);
        by = ay + ($signed($urandom) >>> shift);
        ar = 31'($urandom); br = 31'($urandom);
      end
    endcase
    send_pair(ax, ay, bx, by, ar, br);
  endtask

  always @(posedge clk) begin
    ccc_pkg::res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit = out_ch.hit;
      got.normal_x = out_ch.normal_x;
      got.normal_y = out_ch.normal_y;
      got.penetration = out_ch.penetration;
      board.check_result(got);
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= out_idle_pct);

  initial begin
    in_ch.valid = 0;
    in_ch.a_pos_x = 0; in_ch.a_pos_y = 0; in_ch.b_pos_x = 0; in_ch.b_pos_y = 0;
    in_ch.a_radius = 0; in_ch.b_radius = 0;
    out_ch.ready = 0;
    threshold = ccc_pkg::THR_RESET;
    in_idle_pct = 37; out_idle_pct = 78;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset threshold
    send_pair(0, 0, 0, 0, 0, 0);                         // zero radius sum, no hit
    send_pair(0, 0, 0, 0, 31'h10000, 0);                 // zero distance
    send_pair(0, 0, 32'd40, 32'd50, 31'h10000, 31'h10000); // below threshold
    send_pair(0, 0, 32'h10000, 0, 31'h10000, 31'h10000);
    send_pair(0, 0, 32'hFFFF0000, 32'hFFFF8000, 31'h10000, 31'h10000);
    send_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              31'h7FFFFFFF, 31'h7FFFFFFF);               // 64-bit carry
    send_pair(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              31'h7FFFFFFF, 31'h7FFFFFFF);
    send_pair(0, 0, 32'h7FFFFFFF, 0, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_pair(0, 0, 32'h00030000, 32'h00040000, 31'h00028000, 31'h00028000); // touching
    send_pair(0, 0, 32'h00030000, 32'h00040000, 31'h00028000, 31'h00028001);
    send_pair(5, 5, 5, 6, 0, 1);
    send_pair(32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 31'h7FFFFFFF, 0);
    drain_and_pause();
    write_threshold(16'd0);
    send_pair(7, 7, 7, 7, 31'h1, 31'h0);                 // zero distance, zero threshold
    send_pair(7, 7, 8, 7, 31'h1, 31'h1);
    drain_and_pause();
    write_threshold(16'hFFFF);
    send_pair(0, 0, 32'd255, 0, 31'h100, 0);
    send_pair(0, 0, 32'd256, 0, 31'h200, 0);
    send_pair(0, 0, 32'd180, 32'd181, 31'h200, 0);

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = phase == 0 ? 37 : (phase == 1 ? 78 : 0);
      out_idle_pct = phase == 0 ? 78 : (phase == 1 ? 37 : 0);
      drain_and_pause();
      case (phase)
        0: write_threshold(16'd4295);
        1: write_threshold(16'($urandom));
        default: write_threshold(16'd0);
      endcase
      for (int i = 0; i < 280; i++) send_random_pair();
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.error_count == 0)
      $display("circle_circle_collision_test: done, clean");
    else
      $display("circle_circle_collision_test: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("circle_circle_collision_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
